// File: rtl/core/neighborhood_rank_roulette_select_assert.svh
// Assertion macros used by the checker file.
`ifndef NEIGHBORHOOD_RANK_ROULETTE_SELECT_ASSERT_SVH
`define NEIGHBORHOOD_RANK_ROULETTE_SELECT_ASSERT_SVH

// Implication checked every clock, quiet during reset.
`define NRRS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, quiet during reset.
`define NRRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/nrrs_pkg.sv
package nrrs_pkg;

   localparam int NB_SIZE = 9;
   localparam int NB_SIDE = 3;
   localparam int NB_LAST = 8;
   localparam int RANK_W  = 4;
   localparam int WGT_W   = 16;
   localparam int COORD_W = 10;
   localparam int IDX_W   = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SCHEME = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_W = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_H = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WLOW   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WMID   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WTOP   = 3'd5;

   // scheme codes
   localparam logic [1:0] SCHEME_LINEAR = 2'd0;
   localparam logic [1:0] SCHEME_EXP    = 2'd1;
   localparam logic [1:0] SCHEME_FIT    = 2'd2;
   localparam logic [1:0] SCHEME_PROP   = 2'd3;

   // offset code of an index: 0 means -1, 1 means 0, 2 means +1
   function automatic logic [1:0] dx_code(input logic [IDX_W-1:0] idx);
      logic [1:0] r;
      case (idx)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] dy_code(input logic [IDX_W-1:0] idx);
      logic [1:0] r;
      case (idx)
         4'd0, 4'd3, 4'd6: r = 2'd0;
         4'd1, 4'd4, 4'd7: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   // one compare-subtract step of a coordinate remainder by the grid size
   function automatic logic [COORD_W-1:0] rem_step(input logic [COORD_W-1:0] v,
                                                   input logic [10:0] s, input int b);
      logic [20:0] sh;
      sh = 21'(s) << b;
      return (21'(v) >= sh) ? COORD_W'(21'(v) - sh) : v;
   endfunction

endpackage

// File: rtl/core/nrrs_lane.sv
// One lane: ranks one neighbour against all nine and looks up its weight (the proportional scheme uses its fitness).
module nrrs_lane #(
   parameter int FITNESS_BITS = 32,
   parameter int LANE = 0
) (
   input  logic [nrrs_pkg::NB_SIZE-1:0][FITNESS_BITS-1:0] fit,
   input  logic [1:0]                                     scheme,
   input  logic [63:0]                                    wlow,
   input  logic [63:0]                                    wmid,
   input  logic [15:0]                                    wtop,
   output logic [(FITNESS_BITS > 16 ? FITNESS_BITS : 16)-1:0] weight
);
   localparam int WB = FITNESS_BITS > 16 ? FITNESS_BITS : 16;

   logic [nrrs_pkg::RANK_W-1:0] rank;
   logic [15:0]                 twgt;

   // stable rank: count smaller, and equal with lower index
   always_comb begin
      rank = '0;
      for (int j = 0; j < nrrs_pkg::NB_SIZE; j++) begin
         if (fit[j] < fit[LANE] || (fit[j] == fit[LANE] && j < LANE)) begin
            rank = rank + 4'd1;
         end
      end
   end

   always_comb begin
      case (rank)
         4'd0: twgt = wlow[15:0];
         4'd1: twgt = wlow[31:16];
         4'd2: twgt = wlow[47:32];
         4'd3: twgt = wlow[63:48];
         4'd4: twgt = wmid[15:0];
         4'd5: twgt = wmid[31:16];
         4'd6: twgt = wmid[47:32];
         4'd7: twgt = wmid[63:48];
         default: twgt = wtop;
      endcase
   end

   // weight wide enough for both a fitness and a full table entry
   assign weight = (scheme == nrrs_pkg::SCHEME_PROP) ? WB'(fit[LANE]) : WB'(twgt);
endmodule

// File: rtl/core/nrrs_merge.sv
// Merge: picks the first running sum above the threshold, then wraps coordinates.
module nrrs_merge #(
   parameter int SUM_W = 36
) (
   input  logic [nrrs_pkg::NB_SIZE-1:0][SUM_W-1:0] run,
   input  logic [SUM_W-1:0]                        thr,
   input  logic [nrrs_pkg::COORD_W-1:0]            cx,
   input  logic [nrrs_pkg::COORD_W-1:0]            cy,
   input  logic [10:0]                             gw,
   input  logic [10:0]                             gh,
   output logic [nrrs_pkg::IDX_W-1:0]              idx,
   output logic [nrrs_pkg::COORD_W-1:0]            ox,
   output logic [nrrs_pkg::COORD_W-1:0]            oy
);
   // first exceeding lane, default last
   always_comb begin
      idx = nrrs_pkg::IDX_W'(nrrs_pkg::NB_LAST);
      for (int i = nrrs_pkg::NB_SIZE - 1; i >= 0; i--) begin
         if (run[i] > thr) begin
            idx = nrrs_pkg::IDX_W'(i);
         end
      end
   end

   // c is already below size s: step by k - 1 and wrap at either end
   function automatic logic [nrrs_pkg::COORD_W-1:0] wrapc(
      input logic [nrrs_pkg::COORD_W-1:0] c, input logic [1:0] k, input logic [10:0] s);
      logic [10:0] v;
      v = 11'(c);
      if (k == 2'd0) begin
         v = (v == 11'd0) ? s - 11'd1 : v - 11'd1;
      end else if (k == 2'd2) begin
         v = (v + 11'd1 == s) ? 11'd0 : v + 11'd1;
      end
      return v[nrrs_pkg::COORD_W-1:0];
   endfunction

   assign ox = wrapc(cx, nrrs_pkg::dx_code(idx), gw);
   assign oy = wrapc(cy, nrrs_pkg::dy_code(idx), gh);
endmodule

// File: rtl/core/neighborhood_rank_roulette_select.sv
// Rank/roulette selection over one 3x3 toroidal neighbourhood per transfer.
// Fully pipelined: one item per cycle, four register stages from req to rsp
// (lane weights, running sums, threshold multiply, pick and wrap). Nine
// parallel ranking lanes feed a merging stage; the centre coordinates are
// reduced modulo the grid size along the first three stages. Configuration
// must be written only while the block is idle. A stalled valid result holds
// the whole pipeline and stalls the input.
module neighborhood_rank_roulette_select #(
   parameter int GRID_MAX = 1024,
   parameter int FITNESS_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [9:0]  req_center_x,
   input  logic [9:0]  req_center_y,
   input  logic [31:0] req_fit_0,
   input  logic [31:0] req_fit_1,
   input  logic [31:0] req_fit_2,
   input  logic [31:0] req_fit_3,
   input  logic [31:0] req_fit_4,
   input  logic [31:0] req_fit_5,
   input  logic [31:0] req_fit_6,
   input  logic [31:0] req_fit_7,
   input  logic [31:0] req_fit_8,
   input  logic [31:0] req_random_draw,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_chosen_index,
   output logic [9:0]  rsp_chosen_x,
   output logic [9:0]  rsp_chosen_y,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   localparam int N     = nrrs_pkg::NB_SIZE;
   localparam int FB    = FITNESS_BITS > 32 ? 32 : FITNESS_BITS;
   localparam int WB    = FB > 16 ? FB : 16;
   localparam int SUM_W = WB + 4;

   logic [1:0]  scheme_ff;
   logic [10:0] grid_w_ff, grid_h_ff;
   logic [63:0] wlow_ff, wmid_ff;
   logic [15:0] wtop_ff;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scheme_ff <= nrrs_pkg::SCHEME_FIT;
         grid_w_ff <= 11'd1024;
         grid_h_ff <= 11'd1024;
         wlow_ff   <= '0;
         wmid_ff   <= '0;
         wtop_ff   <= 16'hFFFF;
      end else if (csr_valid) begin
         case (csr_index)
            nrrs_pkg::REG_SCHEME: scheme_ff <= csr_data[1:0];
            nrrs_pkg::REG_GRID_W: grid_w_ff <= csr_data[10:0];
            nrrs_pkg::REG_GRID_H: grid_h_ff <= csr_data[10:0];
            nrrs_pkg::REG_WLOW:   wlow_ff   <= csr_data;
            nrrs_pkg::REG_WMID:   wmid_ff   <= csr_data;
            nrrs_pkg::REG_WTOP:   wtop_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // grid size in use: zero reads as one, capped at GRID_MAX
   function automatic logic [10:0] clamp_grid(input logic [10:0] g);
      logic [10:0] r;
      r = g;
      if (g == 11'd0) r = 11'd1;
      else if (32'(g) > GRID_MAX) r = 11'(GRID_MAX);
      return r;
   endfunction

   logic [10:0] gw_s, gh_s;
   assign gw_s = clamp_grid(grid_w_ff);
   assign gh_s = clamp_grid(grid_h_ff);

   logic adv;
   logic [3:0] v_ff;
   assign adv       = !rsp_stall || !v_ff[3];
   assign req_stall = !adv;
   assign rsp_valid = v_ff[3];

   logic [N-1:0][FB-1:0] fit;
   logic [31:0] fraw [N];
   always_comb begin
      fraw[0] = req_fit_0; fraw[1] = req_fit_1; fraw[2] = req_fit_2;
      fraw[3] = req_fit_3; fraw[4] = req_fit_4; fraw[5] = req_fit_5;
      fraw[6] = req_fit_6; fraw[7] = req_fit_7; fraw[8] = req_fit_8;
      for (int i = 0; i < N; i++) fit[i] = fraw[i][FB-1:0];
   end

   // stage 1: lane weights
   logic [N-1:0][WB-1:0] w_in, w1_ff;
   for (genvar g = 0; g < N; g++) begin : g_lane
      nrrs_lane #(.FITNESS_BITS(FB), .LANE(g)) u_lane (
         .fit(fit), .scheme(scheme_ff), .wlow(wlow_ff), .wmid(wmid_ff),
         .wtop(wtop_ff), .weight(w_in[g]));
   end

   logic [9:0]  cx1_ff, cy1_ff, cx2_ff, cy2_ff, cx3_ff, cy3_ff;
   logic [9:0]  cx1_in, cy1_in, cx2_in, cy2_in, cx3_in, cy3_in;
   logic [31:0] d1_ff;

   // coordinate remainder by the grid size, a few steps per stage
   always_comb begin
      cx1_in = req_center_x;
      cy1_in = req_center_y;
      for (int b = 9; b >= 7; b--) begin
         cx1_in = nrrs_pkg::rem_step(cx1_in, gw_s, b);
         cy1_in = nrrs_pkg::rem_step(cy1_in, gh_s, b);
      end
      cx2_in = cx1_ff;
      cy2_in = cy1_ff;
      for (int b = 6; b >= 4; b--) begin
         cx2_in = nrrs_pkg::rem_step(cx2_in, gw_s, b);
         cy2_in = nrrs_pkg::rem_step(cy2_in, gh_s, b);
      end
      cx3_in = cx2_ff;
      cy3_in = cy2_ff;
      for (int b = 3; b >= 0; b--) begin
         cx3_in = nrrs_pkg::rem_step(cx3_in, gw_s, b);
         cy3_in = nrrs_pkg::rem_step(cy3_in, gh_s, b);
      end
   end

   // stage 2: running sums as a log-depth prefix tree; stage 3: threshold
   logic [N-1:0][SUM_W-1:0] p1, p2, p3;
   logic [N-1:0][SUM_W-1:0] run_in, run2_ff, run3_ff;
   logic [SUM_W+31:0] prod_in;
   logic [SUM_W-1:0] thr3_ff;
   always_comb begin
      for (int i = 0; i < N; i++) begin
         p1[i] = SUM_W'(w1_ff[i]);
         if (i >= 1) p1[i] = p1[i] + SUM_W'(w1_ff[i-1]);
      end
      for (int i = 0; i < N; i++) begin
         p2[i] = p1[i];
         if (i >= 2) p2[i] = p1[i] + p1[i-2];
      end
      for (int i = 0; i < N; i++) begin
         p3[i] = p2[i];
         if (i >= 4) p3[i] = p2[i] + p2[i-4];
      end
      for (int i = 0; i < N; i++) begin
         run_in[i] = p3[i];
         if (i >= 8) run_in[i] = p3[i] + p3[i-8];
      end
   end
   logic [31:0] d2_ff;
   assign prod_in = (SUM_W+32)'(d2_ff) * (SUM_W+32)'(run2_ff[N-1]);

   logic [3:0] idx_in;
   logic [9:0] ox_in, oy_in;
   nrrs_merge #(.SUM_W(SUM_W)) u_merge (
      .run(run3_ff), .thr(thr3_ff), .cx(cx3_ff), .cy(cy3_ff),
      .gw(gw_s), .gh(gh_s), .idx(idx_in), .ox(ox_in), .oy(oy_in));

   logic [3:0] idx_ff;
   logic [9:0] ox_ff, oy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w1_ff   <= w_in;
         cx1_ff  <= cx1_in;         cy1_ff <= cy1_in;
         d1_ff   <= req_random_draw;
         run2_ff <= run_in;
         cx2_ff  <= cx2_in;         cy2_ff <= cy2_in;
         d2_ff   <= d1_ff;
         run3_ff <= run2_ff;
         thr3_ff <= prod_in[SUM_W+31:32];
         cx3_ff  <= cx3_in;         cy3_ff <= cy3_in;
         idx_ff  <= idx_in;
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
      end
   end

   assign rsp_chosen_index = idx_ff;
   assign rsp_chosen_x     = ox_ff;
   assign rsp_chosen_y     = oy_ff;
endmodule

// File: rtl/core/nrrs_checker.sv
`include "neighborhood_rank_roulette_select_assert.svh"
module nrrs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_chosen_index,
   input logic       csr_ready
);
   `NRRS_ASSERT_IMP(a_idx_range, clock, reset, rsp_valid, rsp_chosen_index <= 4'd8, "index above 8")
   `NRRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_chosen_index), "stalled result changed")
   `NRRS_ASSERT_IMP(a_stall_src, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled without output stall")
   `NRRS_ASSERT_IMP(a_csr_rdy, clock, reset, 1'b1, csr_ready, "config port not ready")
endmodule

bind neighborhood_rank_roulette_select nrrs_checker u_nrrs_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_chosen_index(rsp_chosen_index),
   .csr_ready(csr_ready));
